// File: rtl/tcgr_pkg.sv
// Shared constants, types and lookup functions for the text cell glyph renderer.
package tcgr_pkg;

  localparam int GLYPH_WIDTH  = 9;
  localparam int GLYPH_HEIGHT = 18;
  localparam int FONT_BYTES   = 16384;
  localparam int GLYPH_AREA   = GLYPH_WIDTH * GLYPH_HEIGHT;

  localparam int FONT_AW  = $clog2(FONT_BYTES);
  localparam int ADDR_W   = 28;
  localparam int VALUE_W  = 16;
  localparam int PX_W     = $clog2(GLYPH_WIDTH + 1);
  localparam int LROW_W   = $clog2(256 * GLYPH_HEIGHT);
  localparam int LEFT_W   = $clog2(256 * GLYPH_WIDTH);
  localparam int LEFTB_W  = LEFT_W + 4;
  localparam int GROW_W   = 5;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  localparam logic [7:0]  CHAR_FIRST     = 8'h21;
  localparam logic [7:0]  CHAR_LAST      = 8'h7E;
  localparam logic [23:0] CURSOR_RGB     = 24'hEEEEEE;
  localparam logic [5:0]  CURSOR_ROW_MIN = 6'd2;
  localparam logic [5:0]  CURSOR_MARGIN  = 6'd2;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_GLYPH  = 2'd1;
  localparam logic [1:0] MODE_CURSOR = 2'd2;

  localparam logic [1:0] JOB_NONE   = 2'd0;
  localparam logic [1:0] JOB_TEXT   = 2'd1;
  localparam logic [1:0] JOB_GLYPH  = 2'd2;
  localparam logic [1:0] JOB_CURSOR = 2'd3;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [2:0] REG_TEXT_MODE = 3'd0;
  localparam logic [2:0] REG_PITCH     = 3'd1;
  localparam logic [2:0] REG_BPP       = 3'd2;
  localparam logic [2:0] REG_RED_OFF   = 3'd3;
  localparam logic [2:0] REG_GREEN_OFF = 3'd4;
  localparam logic [2:0] REG_BLUE_OFF  = 3'd5;

  typedef struct packed {
    logic        text_mode;
    logic [15:0] line_pitch;
    logic [3:0]  bpp;
    logic [2:0]  red_off;
    logic [2:0]  green_off;
    logic [2:0]  blue_off;
  } cfg_t;

  typedef struct packed {
    logic            load;
    logic            base;
    logic            rd;
    logic            issue;
    logic            last;
    logic [1:0]      ch;
    logic [PX_W-1:0] rd_x;
  } cmd_t;

  typedef struct packed {
    logic [1:0] job;
    logic       printable;
    logic       adv;
  } sts_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'h0000FF;
      4'd2:    rgb = 24'h00FF00;
      4'd3:    rgb = 24'h00FFFF;
      4'd4:    rgb = 24'hFF0000;
      4'd5:    rgb = 24'hFF00FF;
      4'd6:    rgb = 24'h813C12;
      4'd7:    rgb = 24'hCCCCCC;
      4'd8:    rgb = 24'h333333;
      4'd9:    rgb = 24'h7777FF;
      4'd10:   rgb = 24'h72FF72;
      4'd11:   rgb = 24'h55BEBE;
      4'd12:   rgb = 24'hFF7777;
      4'd13:   rgb = 24'hBE55BE;
      4'd14:   rgb = 24'hBF510D;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  function automatic logic [7:0] chan_byte(input logic [23:0] rgb, input logic [1:0] ch);
    logic [7:0] b;
    case (ch)
      CH_RED:   b = rgb[23:16];
      CH_GREEN: b = rgb[15:8];
      default:  b = rgb[7:0];
    endcase
    return b;
  endfunction

endpackage

// File: rtl/tcgr_regs.sv
// Configuration register file behind the APB-style port.
module tcgr_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tcgr_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [tcgr_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [tcgr_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output tcgr_pkg::cfg_t                cfg_o
);

  tcgr_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]     idx;
  logic           wr;

  assign idx        = cfg_paddr[4:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_o      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        tcgr_pkg::REG_TEXT_MODE: cfg_nxt.text_mode  = cfg_pwdata[0];
        tcgr_pkg::REG_PITCH:     cfg_nxt.line_pitch = cfg_pwdata[15:0];
        tcgr_pkg::REG_BPP:       cfg_nxt.bpp        = cfg_pwdata[3:0];
        tcgr_pkg::REG_RED_OFF:   cfg_nxt.red_off    = cfg_pwdata[2:0];
        tcgr_pkg::REG_GREEN_OFF: cfg_nxt.green_off  = cfg_pwdata[2:0];
        tcgr_pkg::REG_BLUE_OFF:  cfg_nxt.blue_off   = cfg_pwdata[2:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tcgr_pkg::REG_TEXT_MODE: cfg_prdata = 32'(cfg_r.text_mode);
      tcgr_pkg::REG_PITCH:     cfg_prdata = 32'(cfg_r.line_pitch);
      tcgr_pkg::REG_BPP:       cfg_prdata = 32'(cfg_r.bpp);
      tcgr_pkg::REG_RED_OFF:   cfg_prdata = 32'(cfg_r.red_off);
      tcgr_pkg::REG_GREEN_OFF: cfg_prdata = 32'(cfg_r.green_off);
      tcgr_pkg::REG_BLUE_OFF:  cfg_prdata = 32'(cfg_r.blue_off);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_mode  <= 1'b0;
      cfg_r.line_pitch <= 16'd0;
      cfg_r.bpp        <= 4'd4;
      cfg_r.red_off    <= 3'd2;
      cfg_r.green_off  <= 3'd1;
      cfg_r.blue_off   <= 3'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/tcgr_dp.sv
// Datapath: decode, font memory, address generation, blend pipeline and output register.
module tcgr_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tcgr_pkg::cfg_t                   cfg_i,
  input  tcgr_pkg::cmd_t                   cmd_i,
  output tcgr_pkg::sts_t                   sts_o,
  input  logic [1:0]                       in_mode,
  input  logic [7:0]                       in_cell_col,
  input  logic [7:0]                       in_cell_row,
  input  logic [4:0]                       in_glyph_row,
  input  logic [15:0]                      in_entry,
  input  logic [13:0]                      in_font_index,
  input  logic [7:0]                       in_font_alpha,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tcgr_pkg::ADDR_W-1:0]      out_write_address,
  output logic [tcgr_pkg::VALUE_W-1:0]     out_write_value,
  output logic                             out_last_write
);

  localparam int AW  = tcgr_pkg::ADDR_W;
  localparam int VW  = tcgr_pkg::VALUE_W;
  localparam int GW  = tcgr_pkg::GLYPH_WIDTH;

  logic [7:0] font_mem [tcgr_pkg::FONT_BYTES];
  logic [7:0] font_q_r;
  logic       rd_d_r;
  logic [7:0] cov_r [GW];

  logic [1:0]                     job_r;
  logic                           prt_r;
  logic [7:0]                     row_r, col_r;
  logic [15:0]                    entry_r;
  logic [tcgr_pkg::LROW_W-1:0]    lrow_r;
  logic [tcgr_pkg::LEFT_W-1:0]    left_r;
  logic [tcgr_pkg::FONT_AW-1:0]   gbase_r;
  logic [AW-1:0]                  mul_r, pix_r;
  logic [tcgr_pkg::LEFTB_W-1:0]   leftb_r;

  logic          s1_valid_r, s1_blend_r, s1_last_r;
  logic [AW-1:0] s1_addr_r;
  logic [15:0]   s1_p1_r, s1_p2_r;
  logic [VW-1:0] s1_fix_r;

  logic          out_valid_r, out_last_r;
  logic [AW-1:0] out_addr_r;
  logic [VW-1:0] out_value_r;

  logic                           text_job, adv, font_wr, shift_en, printable;
  logic [1:0]                     job_dec;
  logic [tcgr_pkg::LROW_W-1:0]    mop;
  logic [tcgr_pkg::LROW_W+15:0]   prod;
  logic [2:0]                     off;
  logic [7:0]                     t, fgc, bgc;
  logic [15:0]                    sum;
  logic [16:0]                    q17;
  logic [5:0]                     grow6;

  // decode the incoming word
  assign grow6     = {1'b0, in_glyph_row};
  assign printable = (in_entry[7:0] >= tcgr_pkg::CHAR_FIRST) &&
                     (in_entry[7:0] <= tcgr_pkg::CHAR_LAST);

  always_comb begin
    job_dec = tcgr_pkg::JOB_NONE;
    case (in_mode)
      tcgr_pkg::MODE_GLYPH: begin
        if (cfg_i.text_mode) begin
          job_dec = tcgr_pkg::JOB_TEXT;
        end else if (grow6 < 6'(tcgr_pkg::GLYPH_HEIGHT)) begin
          job_dec = tcgr_pkg::JOB_GLYPH;
        end
      end
      tcgr_pkg::MODE_CURSOR: begin
        if (!cfg_i.text_mode && grow6 >= tcgr_pkg::CURSOR_ROW_MIN &&
            grow6 + tcgr_pkg::CURSOR_MARGIN < 6'(tcgr_pkg::GLYPH_HEIGHT)) begin
          job_dec = tcgr_pkg::JOB_CURSOR;
        end
      end
      default: job_dec = tcgr_pkg::JOB_NONE;
    endcase
  end

  assign adv             = !out_valid_r || out_ready;
  assign sts_o.job       = job_dec;
  assign sts_o.printable = printable;
  assign sts_o.adv       = adv;

  assign font_wr = cmd_i.load && (in_mode == tcgr_pkg::MODE_LOAD) &&
                   (32'(in_font_index) < tcgr_pkg::FONT_BYTES);

  // font memory
  always_ff @(posedge clk) begin
    if (font_wr) begin
      font_mem[tcgr_pkg::FONT_AW'(in_font_index)] <= in_font_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.rd) begin
      font_q_r <= font_mem[gbase_r + tcgr_pkg::FONT_AW'(cmd_i.rd_x)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_d_r <= 1'b0;
    end else begin
      rd_d_r <= cmd_i.rd;
    end
  end

  // coverage line: fill from the top, drain from the bottom one pixel at a time
  assign shift_en = rd_d_r || (cmd_i.issue && cmd_i.ch == tcgr_pkg::CH_BLUE);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < GW - 1; i++) begin
        cov_r[i] <= cov_r[i+1];
      end
      cov_r[GW-1] <= font_q_r;
    end
  end

  // item fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r <= tcgr_pkg::JOB_NONE;
      prt_r <= 1'b0;
    end else if (cmd_i.load) begin
      job_r <= job_dec;
      prt_r <= printable;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      row_r   <= in_cell_row;
      col_r   <= in_cell_col;
      entry_r <= in_entry;
      lrow_r  <= tcgr_pkg::LROW_W'(32'(in_cell_row) * tcgr_pkg::GLYPH_HEIGHT +
                                   32'(in_glyph_row));
      left_r  <= tcgr_pkg::LEFT_W'(32'(in_cell_col) * GW);
      gbase_r <= tcgr_pkg::FONT_AW'((32'(in_entry[7:0]) - 32'(tcgr_pkg::CHAR_FIRST)) *
                                    tcgr_pkg::GLYPH_AREA + 32'(in_glyph_row) * GW);
    end
  end

  // address generation
  assign text_job = (job_r == tcgr_pkg::JOB_TEXT);
  assign mop      = text_job ? tcgr_pkg::LROW_W'(row_r) : lrow_r;
  assign prod     = mop * cfg_i.line_pitch;

  always_ff @(posedge clk) begin
    mul_r   <= prod[AW-1:0];
    leftb_r <= text_job ? tcgr_pkg::LEFTB_W'(col_r) : left_r * cfg_i.bpp;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.base) begin
      pix_r <= mul_r + AW'(leftb_r);
    end else if (cmd_i.issue && cmd_i.ch == tcgr_pkg::CH_BLUE) begin
      pix_r <= pix_r + AW'(cfg_i.bpp);
    end
  end

  always_comb begin
    case (cmd_i.ch)
      tcgr_pkg::CH_RED:   off = cfg_i.red_off;
      tcgr_pkg::CH_GREEN: off = cfg_i.green_off;
      default:            off = cfg_i.blue_off;
    endcase
    if (text_job) begin
      off = 3'd0;
    end
  end

  assign t   = cov_r[0];
  assign fgc = tcgr_pkg::chan_byte(tcgr_pkg::palette(entry_r[11:8]), cmd_i.ch);
  assign bgc = tcgr_pkg::chan_byte(tcgr_pkg::palette(entry_r[15:12]), cmd_i.ch);

  // stage 1: products and address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.issue) begin
      s1_addr_r  <= pix_r + AW'(off);
      s1_p1_r    <= t * fgc;
      s1_p2_r    <= (8'd255 - t) * bgc;
      s1_blend_r <= (job_r == tcgr_pkg::JOB_GLYPH) && prt_r;
      s1_last_r  <= cmd_i.last;
      case (job_r)
        tcgr_pkg::JOB_TEXT:   s1_fix_r <= entry_r;
        tcgr_pkg::JOB_CURSOR: s1_fix_r <= VW'(tcgr_pkg::chan_byte(tcgr_pkg::CURSOR_RGB,
                                                                  cmd_i.ch));
        default:              s1_fix_r <= '0;
      endcase
    end
  end

  // stage 2: divide by 255 and hold the result word
  assign sum = s1_p1_r + s1_p2_r;
  assign q17 = 17'(sum) + 17'(sum[15:8]) + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_addr_r  <= s1_addr_r;
      out_value_r <= s1_blend_r ? VW'(q17[15:8]) : s1_fix_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_value   = out_value_r;
  assign out_last_write    = out_last_r;

endmodule

// File: rtl/tcgr_ctrl.sv
// Controller state machine: sequences setup, font fetch and write issue per word.
module tcgr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcgr_pkg::sts_t sts_i,
  output tcgr_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_FLAST = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [tcgr_pkg::PX_W-1:0] PX_LAST = tcgr_pkg::PX_W'(tcgr_pkg::GLYPH_WIDTH - 1);

  logic [2:0]                state_r, state_nxt;
  logic [1:0]                job_r, job_nxt;
  logic                      prt_r, prt_nxt;
  logic [tcgr_pkg::PX_W-1:0] px_r, px_nxt;
  logic [1:0]                ch_r, ch_nxt;
  logic                      accept, last_w;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_w   = (job_r == tcgr_pkg::JOB_TEXT) ||
                    (ch_r == tcgr_pkg::CH_BLUE &&
                     (job_r == tcgr_pkg::JOB_CURSOR || px_r == PX_LAST));

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    prt_nxt    = prt_r;
    px_nxt     = px_r;
    ch_nxt     = ch_r;
    cmd_o      = '0;
    cmd_o.ch   = ch_r;
    cmd_o.rd_x = px_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          job_nxt    = sts_i.job;
          prt_nxt    = sts_i.printable;
          px_nxt     = '0;
          ch_nxt     = tcgr_pkg::CH_RED;
          if (sts_i.job != tcgr_pkg::JOB_NONE) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: state_nxt = S_SUM;
      S_SUM: begin
        cmd_o.base = 1'b1;
        state_nxt  = (job_r == tcgr_pkg::JOB_GLYPH && prt_r) ? S_FETCH : S_EMIT;
      end
      S_FETCH: begin
        cmd_o.rd = 1'b1;
        if (px_r == PX_LAST) begin
          px_nxt    = '0;
          state_nxt = S_FLAST;
        end else begin
          px_nxt = px_r + 1'b1;
        end
      end
      S_FLAST: state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts_i.adv) begin
          cmd_o.issue = 1'b1;
          cmd_o.last  = last_w;
          if (last_w) begin
            state_nxt = S_IDLE;
          end else if (ch_r == tcgr_pkg::CH_BLUE) begin
            ch_nxt = tcgr_pkg::CH_RED;
            px_nxt = px_r + 1'b1;
          end else begin
            ch_nxt = ch_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= tcgr_pkg::JOB_NONE;
      prt_r   <= 1'b0;
      px_r    <= '0;
      ch_r    <= tcgr_pkg::CH_RED;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      prt_r   <= prt_nxt;
      px_r    <= px_nxt;
      ch_r    <= ch_nxt;
    end
  end

`ifndef SYNTH
  a_issue_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.issue |-> sts_i.adv)
    else $error("write issued while the pipeline is stalled");

  a_rd_issue: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_o.rd && cmd_o.issue))
    else $error("font fetch overlaps write issue");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.issue && cmd_o.last) |=> (state_r == S_IDLE))
    else $error("controller did not return to idle after the final write");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |-> (state_r == S_IDLE && in_valid))
    else $error("load command outside an accepted word");
`endif

endmodule

// File: rtl/text_cell_glyph_renderer.sv
// Top level of the text cell glyph renderer: register file, controller and datapath.
// Glyph row: S_MUL, S_SUM, then if printable S_FETCH per pixel and S_FLAST, then S_EMIT:
// three writes per pixel, held while the output stalls; cursor row one pixel, text cell one
// word. Font loads and dropped words stay idle. Writes pass stage 1 and output registers.
// Reset (rst_n, synchronous): controller idle, pipeline empty, registers to defaults.
module text_cell_glyph_renderer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_cell_col,
  input  logic [7:0]                    in_cell_row,
  input  logic [4:0]                    in_glyph_row,
  input  logic [15:0]                   in_entry,
  input  logic [13:0]                   in_font_index,
  input  logic [7:0]                    in_font_alpha,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcgr_pkg::ADDR_W-1:0]   out_write_address,
  output logic [tcgr_pkg::VALUE_W-1:0]  out_write_value,
  output logic                          out_last_write,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tcgr_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [tcgr_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [tcgr_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  tcgr_pkg::cfg_t cfg;
  tcgr_pkg::cmd_t cmd;
  tcgr_pkg::sts_t sts;

  tcgr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  tcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  tcgr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_mode           (in_mode),
    .in_cell_col       (in_cell_col),
    .in_cell_row       (in_cell_row),
    .in_glyph_row      (in_glyph_row),
    .in_entry          (in_entry),
    .in_font_index     (in_font_index),
    .in_font_alpha     (in_font_alpha),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_value   (out_write_value),
    .out_last_write    (out_last_write)
  );

endmodule
